// ===== design/pps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the priority power sequencer.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int NUM_ENABLES_DEF = 16;
  localparam int NUM_GOODS_DEF   = 14;

  localparam int ENABLE_W  = 16;
  localparam int GOOD_W    = 14;
  localparam int LEVEL_W   = 3;
  localparam int INDEX_W   = 4;
  localparam int SETTLE_W  = 32;
  localparam int CFG_W     = 48;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEVEL_W-1:0]  NUM_LEVELS_RST = 3'd6;
  localparam logic [SETTLE_W-1:0] SETTLE_RST     = 32'd60000000;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_CHECK = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_EN_PRIO    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PG_PRIO    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_LEVELS = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SETTLE     = 2'd3;

  typedef struct packed {
    logic                low;
    logic [LEVEL_W-1:0]  level;
  } good_lane_t;

  typedef struct packed {
    logic                seq_bad;
    logic [INDEX_W-1:0]  seq_idx;
    logic                chk_bad;
    logic [LEVEL_W-1:0]  chk_level;
    logic [INDEX_W-1:0]  chk_idx;
  } merge_t;

  // first field in the highest bits
  typedef struct packed {
    logic [INDEX_W-1:0]  fail_index;
    logic [LEVEL_W-1:0]  fail_level;
    logic                success;
    logic                done_res;
    logic                busy_res;
    logic [ENABLE_W-1:0] enable_lines;
  } result_t;

endpackage
`default_nettype wire

// ===== design/priority_power_sequencer_unit.sv =====
`default_nettype none
// A word's result is registered in the output register, or in the skid while
// output stalls. One word is taken per cycle while the skid is empty. A
// two-entry output stage (register plus skid) lets input take one more word
// while a result waits. Reset (rst_n low, synchronous) turns all enables
// off, idles the sequencer, restores register defaults and empties the output.
// ----------------------------------------------------------------------------
// priority_power_sequencer_unit
// Level-by-level supply power-up with settle timer and power-good checks.
// ----------------------------------------------------------------------------
module priority_power_sequencer_unit
  import pps_pkg::*;
#(
  parameter int NUM_ENABLES = NUM_ENABLES_DEF,
  parameter int NUM_GOODS   = NUM_GOODS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [1:0] func, [15:2] power_good
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [15:0] enable_lines, [16] busy_res, [17] done_res, [18] success,
  // [21:19] fail_level, [25:22] fail_index, [31:26] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  logic [3*NUM_ENABLES-1:0] en_prio_r;
  logic [3*NUM_GOODS-1:0]   pg_prio_r;
  logic [LEVEL_W-1:0]       num_levels_r;
  logic [SETTLE_W-1:0]      settle_r;

  logic [NUM_ENABLES-1:0]   en_r, en_nxt;
  logic [LEVEL_W-1:0]       level_r, level_nxt;
  logic [SETTLE_W-1:0]      wait_r, wait_nxt;
  logic                     busy_r, busy_nxt;
  logic                     success_r, success_nxt;
  logic [LEVEL_W-1:0]       fail_level_r, fail_level_nxt;
  logic [INDEX_W-1:0]       fail_index_r, fail_index_nxt;
  logic                     done;

  logic [1:0]               func;
  logic [NUM_GOODS-1:0]     pg;
  logic                     accept;

  logic [LEVEL_W-1:0]       set_level, clr_level;
  logic                     do_set, do_clr;
  logic [NUM_ENABLES-1:0]   set_mask, clr_mask;
  good_lane_t               lanes [NUM_GOODS];
  merge_t                   mrg;

  result_t                  res_new;
  result_t                  main_r, skid_r;
  logic                     main_valid_r, skid_valid_r;

  assign func   = in_tdata[1:0];
  assign pg     = in_tdata[2 +: NUM_GOODS];
  assign accept = in_tvalid && in_tready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_prio_r    <= '0;
      pg_prio_r    <= '0;
      num_levels_r <= NUM_LEVELS_RST;
      settle_r     <= SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EN_PRIO:    en_prio_r    <= cfg_wdata[3*NUM_ENABLES-1:0];
        REG_PG_PRIO:    pg_prio_r    <= cfg_wdata[3*NUM_GOODS-1:0];
        REG_NUM_LEVELS: num_levels_r <= cfg_wdata[LEVEL_W-1:0];
        REG_SETTLE:     settle_r     <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // lanes
  for (genvar g = 0; g < NUM_GOODS; g++) begin : g_good
    pps_good_lane u_lane (
      .level (pg_prio_r[3*g +: 3]),
      .pg    (pg[g]),
      .lane  (lanes[g])
    );
  end

  for (genvar e = 0; e < NUM_ENABLES; e++) begin : g_en
    pps_enable_lane u_lane (
      .level     (en_prio_r[3*e +: 3]),
      .set_level (set_level),
      .clr_level (clr_level),
      .set_hit   (set_mask[e]),
      .clr_hit   (clr_mask[e])
    );
  end

  pps_merge #(
    .NUM_GOODS (NUM_GOODS)
  ) u_merge (
    .lanes      (lanes),
    .cur_level  (level_r),
    .num_levels (num_levels_r),
    .res        (mrg)
  );

  // sequencer next state
  always_comb begin
    level_nxt      = level_r;
    wait_nxt       = wait_r;
    busy_nxt       = busy_r;
    success_nxt    = success_r;
    fail_level_nxt = fail_level_r;
    fail_index_nxt = fail_index_r;
    done           = 1'b0;
    do_set         = 1'b0;
    do_clr         = 1'b0;
    set_level      = LEVEL_W'(1);
    clr_level      = mrg.chk_level;

    if (busy_r) begin
      clr_level = level_r;
      set_level = level_r + LEVEL_W'(1);
      if (wait_r > SETTLE_W'(1)) begin
        wait_nxt = wait_r - SETTLE_W'(1);
      end else if (mrg.seq_bad) begin
        do_clr         = 1'b1;
        success_nxt    = 1'b0;
        fail_level_nxt = level_r;
        fail_index_nxt = mrg.seq_idx;
        busy_nxt       = 1'b0;
        done           = 1'b1;
      end else if (level_r >= num_levels_r) begin
        success_nxt    = 1'b1;
        fail_level_nxt = '0;
        fail_index_nxt = '0;
        busy_nxt       = 1'b0;
        done           = 1'b1;
      end else begin
        level_nxt = level_r + LEVEL_W'(1);
        do_set    = 1'b1;
        wait_nxt  = settle_r;
      end
    end else if (func == FUNC_START) begin
      level_nxt = LEVEL_W'(1);
      do_set    = 1'b1;
      wait_nxt  = settle_r;
      busy_nxt  = 1'b1;
    end else if (func == FUNC_CHECK) begin
      done = 1'b1;
      if (mrg.chk_bad) begin
        do_clr         = 1'b1;
        success_nxt    = 1'b0;
        fail_level_nxt = mrg.chk_level;
        fail_index_nxt = mrg.chk_idx;
      end else begin
        success_nxt    = 1'b1;
        fail_level_nxt = '0;
        fail_index_nxt = '0;
      end
    end

    en_nxt = (en_r | (do_set ? set_mask : '0)) & ~(do_clr ? clr_mask : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= '0;
      level_r      <= '0;
      wait_r       <= '0;
      busy_r       <= 1'b0;
      success_r    <= 1'b0;
      fail_level_r <= '0;
      fail_index_r <= '0;
    end else if (accept) begin
      en_r         <= en_nxt;
      level_r      <= level_nxt;
      wait_r       <= wait_nxt;
      busy_r       <= busy_nxt;
      success_r    <= success_nxt;
      fail_level_r <= fail_level_nxt;
      fail_index_r <= fail_index_nxt;
    end
  end

  always_comb begin
    res_new.enable_lines = ENABLE_W'(en_nxt);
    res_new.busy_res     = busy_nxt;
    res_new.done_res     = done;
    res_new.success      = success_nxt;
    res_new.fail_level   = fail_level_nxt;
    res_new.fail_index   = fail_index_nxt;
  end

  // output register with skid
  assign in_tready  = !skid_valid_r;
  assign out_tvalid = main_valid_r;
  assign out_tdata  = OUT_DATA_W'(main_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_tready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !main_valid_r) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= res_new;
      end
    end else if (accept) begin
      skid_r <= res_new;
    end
  end

endmodule
`default_nettype wire

// ===== design/pps_good_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_good_lane
// One power-good input: flags a low, checked supply and passes its level.
// ----------------------------------------------------------------------------
module pps_good_lane
  import pps_pkg::*;
(
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic               pg,
  output good_lane_t              lane
);

  always_comb begin
    lane.low   = !pg && (level != '0);
    lane.level = level;
  end

endmodule
`default_nettype wire

// ===== design/pps_enable_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_enable_lane
// One supply enable: matches its level against the level being turned on
// and the level from which enables are shut down.
// ----------------------------------------------------------------------------
module pps_enable_lane
  import pps_pkg::*;
(
  input  wire logic [LEVEL_W-1:0] level,
  input  wire logic [LEVEL_W-1:0] set_level,
  input  wire logic [LEVEL_W-1:0] clr_level,
  output logic                    set_hit,
  output logic                    clr_hit
);

  assign set_hit = (level == set_level);
  assign clr_hit = (level >= clr_level);

endmodule
`default_nettype wire

// ===== design/pps_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_merge
// Combines the good lanes: first failing index at or below the running level, and
// lowest failing level plus its first index for a check.
// ----------------------------------------------------------------------------
module pps_merge
  import pps_pkg::*;
#(
  parameter int NUM_GOODS = NUM_GOODS_DEF
) (
  input  wire good_lane_t           lanes [NUM_GOODS],
  input  wire logic [LEVEL_W-1:0]   cur_level,
  input  wire logic [LEVEL_W-1:0]   num_levels,
  output merge_t                    res
);

  logic [7:1] lvl_hit;

  always_comb begin
    lvl_hit = '0;
    for (int i = 0; i < NUM_GOODS; i++) begin
      for (int l = 1; l <= 7; l++) begin
        if (lanes[i].low && (lanes[i].level == LEVEL_W'(l))) begin
          lvl_hit[l] = 1'b1;
        end
      end
    end

    res = '0;
    for (int l = 7; l >= 1; l--) begin
      if (lvl_hit[l] && (LEVEL_W'(l) <= num_levels)) begin
        res.chk_bad   = 1'b1;
        res.chk_level = LEVEL_W'(l);
      end
    end

    for (int i = NUM_GOODS - 1; i >= 0; i--) begin
      if (lanes[i].low && (lanes[i].level == res.chk_level)) begin
        res.chk_idx = INDEX_W'(i);
      end
      if (lanes[i].low && (lanes[i].level <= cur_level)) begin
        res.seq_bad = 1'b1;
        res.seq_idx = INDEX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/pps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks of the power sequencer's result words.
// ----------------------------------------------------------------------------
module pps_checker
  import pps_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a finishing word never reports the sequence still running
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |-> !out_tdata[16])
    else $error("done and busy together");

  // success clears the failure record
  a_success_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18] |-> out_tdata[21:19] == '0 && out_tdata[25:22] == '0)
    else $error("success with failure record");

  // a failure always names a level
  a_fail_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] && !out_tdata[18] |-> out_tdata[21:19] != '0)
    else $error("failure without level");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("word present after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled word changed");

endmodule

bind priority_power_sequencer_unit pps_checker u_pps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== tb/priority_power_sequencer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_power_sequencer_unit_test
// Runs directed and random input words through the sequencer, with random
// gaps on the input and random stalls on the output. Every result word is
// checked field by field against an in-bench model of the level sequencer.
// ----------------------------------------------------------------------------
module priority_power_sequencer_unit_test;
  import pps_pkg::*;

  localparam logic [1:0]        FUNC_SPARE  = 2'd3;
  localparam logic [GOOD_W-1:0] PG_HEALTHY  = '1;
  // enable line i at level i mod 8; good i at level i mod 7 + 1, good 13 unchecked
  localparam logic [47:0]       DIR_EN_PRIO = 48'o7654321076543210;
  localparam logic [41:0]       DIR_PG_PRIO = 42'o06543217654321;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire [OUT_DATA_W-1:0]  out_tdata;

  // model configuration and state
  logic [47:0]          cfg_en_prio = '0;
  logic [41:0]          cfg_pg_prio = '0;
  logic [LEVEL_W-1:0]   cfg_levels  = NUM_LEVELS_RST;
  logic [SETTLE_W-1:0]  cfg_settle  = SETTLE_RST;
  logic [ENABLE_W-1:0]  st_enables  = '0;
  logic [LEVEL_W-1:0]   st_level    = '0;
  logic [SETTLE_W-1:0]  st_wait     = '0;
  logic                 st_busy     = 1'b0;
  logic                 st_ok       = 1'b0;
  logic [LEVEL_W-1:0]   st_flevel   = '0;
  logic [INDEX_W-1:0]   st_findex   = '0;

  result_t expected_status[$];
  int      mismatches = 0;
  int      gap_pct    = 0;
  int      stall_pct  = 0;
  int      stall_left = 0;

  always #1 clk = ~clk;

  priority_power_sequencer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [ENABLE_W-1:0] enable_mask(input int lvl, input bit at_or_above);
    logic [ENABLE_W-1:0] m;
    int l;
    m = '0;
    for (int i = 0; i < ENABLE_W; i++) begin
      l = int'(cfg_en_prio[3*i +: 3]);
      if (at_or_above ? (l >= lvl) : (l == lvl)) m[i] = 1'b1;
    end
    return m;
  endfunction

  function automatic int first_low(input logic [GOOD_W-1:0] pg, input int lvl);
    int p;
    for (int i = 0; i < GOOD_W; i++) begin
      p = int'(cfg_pg_prio[3*i +: 3]);
      if (p != 0 && p <= lvl && !pg[i]) return i;
    end
    return -1;
  endfunction

  function automatic void latch_failure(input int lvl, input int idx);
    st_enables &= ~enable_mask(lvl, 1'b1);
    st_ok     = 1'b0;
    st_flevel = lvl[LEVEL_W-1:0];
    st_findex = idx[INDEX_W-1:0];
  endfunction

  function automatic void latch_success();
    st_ok     = 1'b1;
    st_flevel = '0;
    st_findex = '0;
  endfunction

  function automatic result_t advance_sequencer(input logic [1:0] fn,
                                                input logic [GOOD_W-1:0] pg);
    result_t r;
    int      bad;
    int      lv;
    logic    done;
    done = 1'b0;
    if (st_busy) begin
      if (st_wait > 1) begin
        st_wait--;
      end else begin
        bad = first_low(pg, int'(st_level));
        if (bad >= 0) begin
          latch_failure(int'(st_level), bad);
          st_busy = 1'b0;
          done    = 1'b1;
        end else if (st_level >= cfg_levels) begin
          latch_success();
          st_busy = 1'b0;
          done    = 1'b1;
        end else begin
          st_level   = st_level + 1'b1;
          st_enables |= enable_mask(int'(st_level), 1'b0);
          st_wait    = cfg_settle;
        end
      end
    end else if (fn == FUNC_START) begin
      st_level   = 3'd1;
      st_enables |= enable_mask(1, 1'b0);
      st_wait    = cfg_settle;
      st_busy    = 1'b1;
    end else if (fn == FUNC_CHECK) begin
      bad = -1;
      for (lv = 1; lv <= 7 && lv <= int'(cfg_levels); lv++) begin
        bad = first_low(pg, lv);
        if (bad >= 0) break;
      end
      if (bad >= 0) latch_failure(lv, bad);
      else latch_success();
      done = 1'b1;
    end
    r.enable_lines = st_enables;
    r.busy_res     = st_busy;
    r.done_res     = done;
    r.success      = st_ok;
    r.fail_level   = st_flevel;
    r.fail_index   = st_findex;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          compare_field("enable_lines", 32'(want.enable_lines), 32'(got.enable_lines));
          compare_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
          compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
          compare_field("success", 32'(want.success), 32'(got.success));
          compare_field("fail_level", 32'(want.fail_level), 32'(got.fail_level));
          compare_field("fail_index", 32'(want.fail_index), 32'(got.fail_index));
        end
      end
      if (in_tvalid && in_tready)
        expected_status.push_back(advance_sequencer(in_tdata[1:0], in_tdata[IN_DATA_W-1:2]));
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < stall_pct) stall_left <= pick_gap();
    end
  end

  task automatic send_word(input logic [1:0] fn, input logic [GOOD_W-1:0] pg);
    int n;
    if ($urandom_range(0, 99) < gap_pct) begin
      n = pick_gap();
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'($urandom);
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pg, fn};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [47:0] en, input logic [41:0] pg,
                              input logic [LEVEL_W-1:0] levels,
                              input logic [SETTLE_W-1:0] settle);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_EN_PRIO;
    cfg_wdata <= CFG_W'(en);
    @(posedge clk);
    cfg_en_prio = en;
    cfg_addr  <= REG_PG_PRIO;
    cfg_wdata <= CFG_W'(pg);
    @(posedge clk);
    cfg_pg_prio = pg;
    cfg_addr  <= REG_NUM_LEVELS;
    cfg_wdata <= CFG_W'(levels);
    @(posedge clk);
    cfg_levels = levels;
    cfg_addr  <= REG_SETTLE;
    cfg_wdata <= CFG_W'(settle);
    @(posedge clk);
    cfg_settle = settle;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [GOOD_W-1:0] random_good();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return PG_HEALTHY;
    if (r < 90) return PG_HEALTHY & ~(GOOD_W'(1) << $urandom_range(0, GOOD_W - 1));
    return GOOD_W'($urandom);
  endfunction

  function automatic logic [1:0] random_func(input bit busy);
    int r;
    r = $urandom_range(0, 99);
    if (busy) return (r < 90) ? FUNC_TICK : ((r < 95) ? FUNC_START : FUNC_CHECK);
    if (r < 55) return FUNC_START;
    if (r < 80) return FUNC_CHECK;
    if (r < 93) return FUNC_TICK;
    return FUNC_SPARE;
  endfunction

  task automatic test_reset_state();
    send_word(FUNC_TICK, '0);
    send_word(FUNC_CHECK, '0);
    send_word(FUNC_SPARE, PG_HEALTHY);
  endtask

  task automatic test_directed_levels();
    program_regs(DIR_EN_PRIO, DIR_PG_PRIO, 3'd7, 32'd1);
    send_word(FUNC_CHECK, PG_HEALTHY);
    send_word(FUNC_CHECK, '0);
    send_word(FUNC_CHECK, PG_HEALTHY & ~(GOOD_W'(1) << 4));
    send_word(FUNC_CHECK, PG_HEALTHY & ~(GOOD_W'(1) << 13));
    send_word(FUNC_START, PG_HEALTHY);
    // commands during a sequence act as plain ticks
    send_word(FUNC_CHECK, PG_HEALTHY);
    send_word(FUNC_START, PG_HEALTHY);
    repeat (6) send_word(FUNC_TICK, PG_HEALTHY);
    send_word(FUNC_CHECK, PG_HEALTHY & ~(GOOD_W'(1) << 9));
    send_word(FUNC_START, PG_HEALTHY);
    send_word(FUNC_TICK, PG_HEALTHY);
    send_word(FUNC_TICK, PG_HEALTHY & ~(GOOD_W'(1) << 1));
    send_word(FUNC_SPARE, '0);
    send_word(FUNC_TICK, '0);
  endtask

  task automatic test_corner_settings();
    // zero levels and zero settle
    program_regs(DIR_EN_PRIO, DIR_PG_PRIO, 3'd0, 32'd0);
    send_word(FUNC_START, PG_HEALTHY);
    send_word(FUNC_TICK, PG_HEALTHY);
    send_word(FUNC_CHECK, '0);
    // goods above the top level are not checked
    program_regs(DIR_EN_PRIO, DIR_PG_PRIO, 3'd2, 32'd3);
    send_word(FUNC_CHECK, PG_HEALTHY & ~(GOOD_W'(1) << 4));
    send_word(FUNC_START, PG_HEALTHY);
    repeat (7) send_word(FUNC_TICK, PG_HEALTHY);
  endtask

  task automatic test_extreme_settings();
    int r;
    gap_pct   = 20;
    stall_pct = 20;
    // settle at its maximum: no sequence is started here
    program_regs('1, '1, 3'd7, '1);
    repeat (40) begin
      r = $urandom_range(0, 2);
      send_word((r == 0) ? FUNC_TICK : ((r == 1) ? FUNC_CHECK : FUNC_SPARE), random_good());
    end
    program_regs('0, '0, 3'd1, 32'd1);
    repeat (20) send_word(random_func(st_busy), random_good());
  endtask

  task automatic test_random_sequences();
    logic [SETTLE_W-1:0] settle;
    for (int phase = 0; phase < 8; phase++) begin
      gap_pct   = (phase % 3 == 0) ? 0 : 5 * phase;
      stall_pct = (phase % 4 == 1) ? 0 : 4 * phase + 5;
      settle    = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      program_regs(48'({$urandom, $urandom}), 42'({$urandom, $urandom}),
                   LEVEL_W'($urandom_range(1, 7)), settle);
      for (int n = 0; n < 190; n++) begin
        if (phase == 2 && n == 95) wait_idle();
        send_word(random_func(st_busy), random_good());
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_levels();
    test_corner_settings();
    test_extreme_settings();
    test_random_sequences();
    wait_idle();
    if (mismatches == 0) begin
      $display("[priority_power_sequencer_unit] OK");
    end else begin
      $display("[priority_power_sequencer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[priority_power_sequencer_unit] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
design/pps_pkg.sv
design/pps_good_lane.sv
design/pps_enable_lane.sv
design/pps_merge.sv
design/priority_power_sequencer_unit.sv
design/pps_checker.sv
tb/priority_power_sequencer_unit_test.sv
